// File: src/ec_host_port_register_file_top_assert.svh
// Assertion macros used by the host port register file RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef EC_HOST_PORT_REGISTER_FILE_TOP_ASSERT_SVH
`define EC_HOST_PORT_REGISTER_FILE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EHPRF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehprf: implication check failed");

// antecedent implies consequent in the next cycle
`define EHPRF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehprf: next-cycle check failed");

`endif

// File: src/ehprf_pkg.sv
// Package for the host port register file: codes, constants, VPD decode.
// No dependencies.
package ehprf_pkg;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 8;
    localparam int LADDR_W  = 11;
    localparam int STAT_W   = 2;
    localparam int PHASE_W  = 2;
    localparam int CMD_W    = 16;
    localparam int ID_W     = 16;
    localparam int TBL_W    = 2;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    localparam int REG_COUNT_DEF = 1792;
    localparam int VPD_DEPTH_DEF = 512;
    localparam int VPD_TBL_CNT   = 4;

    localparam logic [ID_W-1:0]   CHIP_ID_RST = 16'h8528;
    localparam logic [APB_AW-1:0] ADDR_CHIP_ID = 2'd0;

    // func codes
    localparam logic [FUNC_W-1:0] F_INDEX   = 3'd0;
    localparam logic [FUNC_W-1:0] F_ID_DATA = 3'd1;
    localparam logic [FUNC_W-1:0] F_CMD     = 3'd2;
    localparam logic [FUNC_W-1:0] F_DATA    = 3'd3;
    localparam logic [FUNC_W-1:0] F_PRE_REG = 3'd4;
    localparam logic [FUNC_W-1:0] F_PRE_VPD = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CMD = 2'd1;
    localparam logic [STAT_W-1:0] ST_IDLE_WR = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

    // transaction phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HIGH  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LOW   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_WDATA = 2'd3;

    // VPD register positions inside a triple
    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_DATA = 2'd2;

    localparam logic [DATA_W-1:0] CMD_START = 8'h88;
    localparam logic [DATA_W-1:0] IDX_ID_HI = 8'h20;
    localparam logic [DATA_W-1:0] IDX_ID_LO = 8'h21;
    localparam logic [DATA_W-1:0] ID_NONE   = 8'hff;
    localparam int                CMD_WR_BIT = 15;

    localparam logic [CMD_W-1:0] VPD_BASE [VPD_TBL_CNT] = '{16'h56, 16'h59, 16'h5c, 16'h60};

    typedef struct packed {
        logic             hit;
        logic [TBL_W-1:0] tbl;
        logic [1:0]       pos;
    } vpd_hit_t;

    function automatic vpd_hit_t vpd_find(input logic [CMD_W-1:0] r);
        vpd_hit_t         h;
        logic [CMD_W-1:0] d;
        h = '0;
        for (int t = 0; t < VPD_TBL_CNT; t++)
        begin
            d = r - VPD_BASE[t];
            if (r >= VPD_BASE[t] && d < 16'd3)
            begin
                h.hit = 1'b1;
                h.tbl = TBL_W'(t);
                h.pos = d[1:0];
            end
        end
        return h;
    endfunction

endpackage

// File: src/ehprf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ehprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/ehprf_clear.sv
// Post-reset sweep counter that zeroes the register file and VPD store.
// No dependencies.
module ehprf_clear #(
    parameter int LEN = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   active,
    output logic [$clog2(LEN)-1:0] addr
);

    localparam int CW = $clog2(LEN);

    logic          active_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == CW'(LEN - 1))
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign active = active_reg;
    assign addr   = cnt_reg;

endmodule

// File: src/ehprf_core.sv
// Transaction engine: port decode, command phases, register file and VPD memories.
// Depends on ehprf_pkg, ehprf_ram, ehprf_clear and the assertion macro header.
`include "ec_host_port_register_file_top_assert.svh"

module ehprf_core #(
    parameter int REG_COUNT = ehprf_pkg::REG_COUNT_DEF,
    parameter int VPD_DEPTH = ehprf_pkg::VPD_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic [ehprf_pkg::FUNC_W-1:0]   func,
    input  logic                           is_write,
    input  logic [ehprf_pkg::DATA_W-1:0]   wdata,
    input  logic [ehprf_pkg::LADDR_W-1:0]  load_addr,
    input  logic [ehprf_pkg::ID_W-1:0]     chip_id,
    output logic [ehprf_pkg::DATA_W-1:0]   rdata,
    output logic [ehprf_pkg::STAT_W-1:0]   status_code
);

    import ehprf_pkg::*;

    localparam int RAW       = $clog2(REG_COUNT);
    localparam int VPD_TOTAL = VPD_TBL_CNT * VPD_DEPTH;
    localparam int VAW       = $clog2(VPD_TOTAL);
    localparam int VDW       = $clog2(VPD_DEPTH);
    localparam int CLR_LEN   = (REG_COUNT > VPD_TOTAL) ? REG_COUNT : VPD_TOTAL;
    localparam int CLR_W     = $clog2(CLR_LEN);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                state_reg, state_next;
    logic [DATA_W-1:0]   sidx_reg, sidx_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                ofull_reg, ofull_next;
    logic [DATA_W-1:0]   obyte_reg, obyte_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CMD_W-1:0]    vpd_off_reg [VPD_TBL_CNT];
    logic [CMD_W-1:0]    vpd_off_next [VPD_TBL_CNT];

    // latched item
    logic [FUNC_W-1:0]   func_reg;
    logic                wr_reg;
    logic [DATA_W-1:0]   wd_reg;
    logic [LADDR_W-1:0]  la_reg;
    vpd_hit_t            hit_reg;
    logic [CMD_W-1:0]    off_sel_reg;

    logic                accept;
    logic                clr_active;
    logic [CLR_W-1:0]    clr_addr;
    logic [CMD_W-1:0]    reg_sel;
    vpd_hit_t            hit_a;
    logic [CMD_W-1:0]    off_a;
    logic [CMD_W-1:0]    cmd_lo;

    logic                rf_we;
    logic [RAW-1:0]      rf_waddr;
    logic [DATA_W-1:0]   rf_wdata;
    logic [RAW-1:0]      rf_raddr;
    logic [DATA_W-1:0]   rf_rdata;
    logic                vpd_we;
    logic [VAW-1:0]      vpd_waddr;
    logic [DATA_W-1:0]   vpd_wdata;
    logic [VAW-1:0]      vpd_raddr;
    logic [DATA_W-1:0]   vpd_rdata;

    logic                ex_rf_we;
    logic [RAW-1:0]      ex_rf_addr;
    logic                ex_vpd_we;
    logic [DATA_W-1:0]   rd_c;
    logic [STAT_W-1:0]   st_c;
    logic [DATA_W-1:0]   rd_val;

    assign busy   = clr_active || (state_reg == S_EXEC);
    assign done   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    ehprf_clear #(
        .LEN (CLR_LEN)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (clr_active),
        .addr   (clr_addr)
    );

    // Accept cycle: pick the register the item may touch and issue memory reads.
    assign cmd_lo   = {cmd_reg[CMD_W-1:DATA_W], wdata};
    assign reg_sel  = (phase_reg == PH_WDATA) ? cmd_reg : cmd_lo;
    assign hit_a    = vpd_find(reg_sel);
    assign off_a    = vpd_off_reg[hit_a.tbl];
    assign rf_raddr = reg_sel[RAW-1:0];
    assign vpd_raddr = VAW'(VAW'(hit_a.tbl) * VAW'(VPD_DEPTH) + VAW'(off_a[VDW-1:0]));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            wr_reg      <= is_write;
            wd_reg      <= wdata;
            la_reg      <= load_addr;
            hit_reg     <= hit_a;
            off_sel_reg <= off_a;
        end
    end

    // register read data for a read transaction
    always_comb
    begin
        if (hit_reg.hit && hit_reg.pos == POS_DATA)
        begin
            rd_val = (32'(off_sel_reg) >= 32'(VPD_DEPTH)) ? '0 : vpd_rdata;
        end
        else
        begin
            rd_val = rf_rdata;
        end
    end

    always_comb
    begin
        logic [CMD_W-1:0] cl;
        cl         = {cmd_reg[CMD_W-1:DATA_W], wd_reg};
        state_next = state_reg;
        sidx_next  = sidx_reg;
        phase_next = phase_reg;
        ofull_next = ofull_reg;
        obyte_next = obyte_reg;
        cmd_next   = cmd_reg;
        vpd_off_next = vpd_off_reg;
        ex_rf_we   = 1'b0;
        ex_rf_addr = cmd_reg[RAW-1:0];
        ex_vpd_we  = 1'b0;
        rd_c       = '0;
        st_c       = ST_OK;

        if (state_reg == S_IDLE)
        begin
            if (accept)
            begin
                state_next = S_EXEC;
            end
        end
        else
        begin
            state_next = S_IDLE;
            case (func_reg)
                F_INDEX:
                begin
                    if (wr_reg)
                        sidx_next = wd_reg;
                    else
                        rd_c = sidx_reg;
                end
                F_ID_DATA:
                begin
                    if (!wr_reg)
                    begin
                        if (sidx_reg == IDX_ID_HI)
                            rd_c = chip_id[ID_W-1:DATA_W];
                        else if (sidx_reg == IDX_ID_LO)
                            rd_c = chip_id[DATA_W-1:0];
                        else
                            rd_c = ID_NONE;
                    end
                end
                F_CMD:
                begin
                    if (wr_reg)
                    begin
                        if (wd_reg == CMD_START)
                            phase_next = PH_HIGH;
                        else
                            st_c = ST_BAD_CMD;
                    end
                    else
                    begin
                        rd_c = {{(DATA_W-1){1'b0}}, ofull_reg};
                    end
                end
                F_DATA:
                begin
                    if (!wr_reg)
                    begin
                        rd_c       = obyte_reg;
                        obyte_next = '0;
                        ofull_next = 1'b0;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_IDLE:
                            begin
                                st_c = ST_IDLE_WR;
                            end
                            PH_HIGH:
                            begin
                                cmd_next   = {wd_reg, {DATA_W{1'b0}}};
                                phase_next = PH_LOW;
                            end
                            PH_LOW:
                            begin
                                if (cl[CMD_WR_BIT])
                                begin
                                    cmd_next   = {1'b0, cl[CMD_WR_BIT-1:0]};
                                    phase_next = PH_WDATA;
                                end
                                else
                                begin
                                    cmd_next = cl;
                                    if (32'(cl) >= 32'(REG_COUNT))
                                    begin
                                        obyte_next = '0;
                                        st_c       = ST_RANGE;
                                    end
                                    else
                                    begin
                                        obyte_next = rd_val;
                                    end
                                    ofull_next = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            default:
                            begin
                                if (32'(cmd_reg) >= 32'(REG_COUNT))
                                begin
                                    st_c = ST_RANGE;
                                end
                                else
                                begin
                                    ex_rf_we = 1'b1;
                                    if (hit_reg.hit && hit_reg.pos == POS_HIGH)
                                        vpd_off_next[hit_reg.tbl] = {wd_reg, {DATA_W{1'b0}}};
                                    else if (hit_reg.hit && hit_reg.pos == POS_LOW)
                                        vpd_off_next[hit_reg.tbl] =
                                            off_sel_reg | CMD_W'(wd_reg);
                                end
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                F_PRE_REG:
                begin
                    if (32'(la_reg) < 32'(REG_COUNT))
                    begin
                        ex_rf_we   = 1'b1;
                        ex_rf_addr = RAW'(la_reg);
                    end
                end
                F_PRE_VPD:
                begin
                    if (32'(la_reg) < 32'(VPD_TOTAL))
                        ex_vpd_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sidx_reg  <= '0;
            phase_reg <= PH_IDLE;
            ofull_reg <= 1'b0;
            obyte_reg <= '0;
            cmd_reg   <= '0;
            for (int t = 0; t < VPD_TBL_CNT; t++)
            begin
                vpd_off_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            sidx_reg    <= sidx_next;
            phase_reg   <= phase_next;
            ofull_reg   <= ofull_next;
            obyte_reg   <= obyte_next;
            cmd_reg     <= cmd_next;
            vpd_off_reg <= vpd_off_next;
        end
    end

    // memory write ports: clear sweep has priority, block is busy during it
    always_comb
    begin
        if (clr_active)
        begin
            rf_we     = (32'(clr_addr) < 32'(REG_COUNT));
            rf_waddr  = RAW'(clr_addr);
            rf_wdata  = '0;
            vpd_we    = (32'(clr_addr) < 32'(VPD_TOTAL));
            vpd_waddr = VAW'(clr_addr);
            vpd_wdata = '0;
        end
        else
        begin
            rf_we     = ex_rf_we;
            rf_waddr  = ex_rf_addr;
            rf_wdata  = wd_reg;
            vpd_we    = ex_vpd_we;
            vpd_waddr = VAW'(la_reg);
            vpd_wdata = wd_reg;
        end
    end

    ehprf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_rf_ram (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    ehprf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VPD_TOTAL)
    ) u_vpd_ram (
        .clk   (clk),
        .we    (vpd_we),
        .waddr (vpd_waddr),
        .wdata (vpd_wdata),
        .raddr (vpd_raddr),
        .rdata (vpd_rdata)
    );

    assign rdata       = rd_c;
    assign status_code = st_c;

    `EHPRF_ASSERT_NXT(a_accept_done, accept, done)
    `EHPRF_ASSERT_NXT(a_done_single, done, !done)
    `EHPRF_ASSERT_IMP(a_no_done_in_clear, clr_active, !done)
    `EHPRF_ASSERT_IMP(a_wdata_cmd_masked, phase_reg == PH_WDATA, !cmd_reg[CMD_WR_BIT])
    `EHPRF_ASSERT_IMP(a_err_on_write, done && status_code != ST_OK, wr_reg)

endmodule

// File: src/ehprf_cfg.sv
// APB-style configuration register bank holding the chip identifier.
// Depends on ehprf_pkg.
module ehprf_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ehprf_pkg::APB_AW-1:0]  paddr,
    input  logic [ehprf_pkg::APB_DW-1:0]  pwdata,
    output logic [ehprf_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output logic [ehprf_pkg::ID_W-1:0]    chip_id
);

    import ehprf_pkg::*;

    logic [ID_W-1:0] chip_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_id_reg <= CHIP_ID_RST;
        end
        else if (psel && penable && pwrite && paddr == ADDR_CHIP_ID)
        begin
            chip_id_reg <= pwdata[ID_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_CHIP_ID) ? APB_DW'(chip_id_reg) : '0;
    assign chip_id = chip_id_reg;

endmodule

// File: src/ec_host_port_register_file_top.sv
// Embedded controller host port block: byte port accesses, register transactions
// over a memory-backed register file, four VPD tables. Each item is one byte access
// taken when start is high and busy is low; its one result is shown on rdata and
// status_code for exactly one cycle, the cycle after acceptance, marked by done.
// The receiver cannot stall, and a new item is taken only after the last result is
// shown: the accept cycle issues the synchronous read of the register file and VPD
// memories, the next cycle applies the update and presents the result. After reset
// the block zeroes both memories, sweeping max(REG_COUNT, 4*VPD_DEPTH) addresses
// (2048 at the defaults) with busy high; configuration writes are taken throughout.
// Depends on ehprf_pkg, ehprf_cfg, ehprf_core.
module ec_host_port_register_file_top #(
    parameter int REG_COUNT = ehprf_pkg::REG_COUNT_DEF,
    parameter int VPD_DEPTH = ehprf_pkg::VPD_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [ehprf_pkg::FUNC_W-1:0]  func,
    input  logic                          is_write,
    input  logic [ehprf_pkg::DATA_W-1:0]  wdata,
    input  logic [ehprf_pkg::LADDR_W-1:0] load_addr,
    output logic [ehprf_pkg::DATA_W-1:0]  rdata,
    output logic [ehprf_pkg::STAT_W-1:0]  status_code,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ehprf_pkg::APB_AW-1:0]  paddr,
    input  logic [ehprf_pkg::APB_DW-1:0]  pwdata,
    output logic [ehprf_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    import ehprf_pkg::*;

    logic [ID_W-1:0] chip_id;

    ehprf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .chip_id (chip_id)
    );

    ehprf_core #(
        .REG_COUNT (REG_COUNT),
        .VPD_DEPTH (VPD_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .func        (func),
        .is_write    (is_write),
        .wdata       (wdata),
        .load_addr   (load_addr),
        .chip_id     (chip_id),
        .rdata       (rdata),
        .status_code (status_code)
    );

endmodule
